>>> hw/rtl/fbpa_pkg.sv
package fbpa_pkg;

    // Field widths of the item and result ports and of the registers.
    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 16;
    localparam int USE_W    = 12;
    localparam int CFG_W    = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    // Operation codes of an input item.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY        = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BYTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFERS_IN_USE = 2'd2;

    localparam logic [ADDR_W-1:0] BASE_RESET = 32'd0;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd2048;
    localparam logic [USE_W-1:0]  USE_RESET  = 12'd2048;

    // Depth of the small queues between the parts of the block.
    localparam int Q_DEPTH = 2;
    localparam int QPW     = $clog2(Q_DEPTH);

    // Address mapping as seen by both halves; size is already forced to at least one.
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] size;
    } t_map_cfg;

    // A classified request as handed from the front to the back.
    typedef struct packed {
        logic              op;
        logic              bad;
        logic [ADDR_W-1:0] offset;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
    } t_result;

endpackage

>>> hw/rtl/fixed_buffer_pool_allocator_top.sv
// Fixed-size buffer pool allocator. The pool is POOL_DEPTH equal buffers of
// buffer_bytes each, starting at pool_base; free buffers are handed out oldest
// first from a ring of indices, and a per-buffer flag catches double frees.
// Push an item with operation 0 to allocate (the result carries the buffer
// address, or status pool empty) or operation 1 with free_address to return a
// buffer (status invalid pointer when the address is outside the pool or not
// on a buffer boundary, already free when the buffer is not allocated).
// The back end works on one item at a time: an allocate goes through ring
// read, multiply, add and hand-off; a free that passes the range check runs
// a bit-serial divide that turns the offset into an index, then reads the
// buffer's flag, or ends there when the address is off a buffer boundary;
// a rejected or empty item goes straight to hand-off. The front
// end and two-entry queues on both sides let a new item be taken and a result
// wait to be popped while the back end is busy. After reset, and after every
// write of buffers_in_use, the pool rebuilds its free ring and free flags in a
// pass over every entry during which full stays high; configuration
// writes are still taken then.
module fixed_buffer_pool_allocator_top #(
    parameter int POOL_DEPTH = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              push,
    output logic                              full,
    input  logic                              i_operation,
    input  logic [fbpa_pkg::ADDR_W-1:0]       i_free_address,

    output logic                              empty,
    input  logic                              pop,
    output logic [fbpa_pkg::STATUS_W-1:0]     o_status,
    output logic [fbpa_pkg::ADDR_W-1:0]       o_buffer_address,

    input  logic                              i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fbpa_pkg::CFG_W-1:0]        i_cfg_data
);
    import fbpa_pkg::*;

    localparam int CW = $clog2(POOL_DEPTH + 1);

    // Configuration registers.
    logic [ADDR_W-1:0] r_pool_base;
    logic [SIZE_W-1:0] r_buffer_bytes;
    logic [USE_W-1:0]  r_buffers_in_use;
    // Holds the input off in the cycle after a write so the registered span settles.
    logic              r_cfg_hold;

    logic              init_pool;
    t_map_cfg          map_cfg;
    logic [CW-1:0]     count_eff;
    logic [SIZE_W-1:0] size_eff;

    t_cmd              cmd_in;
    t_cmd              cmd_out;
    logic              cmd_push;
    logic              cmd_full;
    logic              cmd_pop;
    logic              cmd_empty;
    t_result           res_in;
    t_result           res_out;
    logic              res_push;
    logic              res_full;
    logic              back_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base      <= BASE_RESET;
            r_buffer_bytes   <= SIZE_RESET;
            r_buffers_in_use <= USE_RESET;
            r_cfg_hold       <= 1'b0;
        end else begin
            r_cfg_hold <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_POOL_BASE:      r_pool_base      <= i_cfg_data[ADDR_W-1:0];
                    CFG_BUFFER_BYTES:   r_buffer_bytes   <= i_cfg_data[SIZE_W-1:0];
                    CFG_BUFFERS_IN_USE: r_buffers_in_use <= i_cfg_data[USE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // A new buffer count rebuilds the pool; base and size only change the mapping.
    assign init_pool = i_cfg_we && (i_cfg_index == CFG_BUFFERS_IN_USE);

    // The count is clipped to the built depth, and a size of zero acts as one byte.
    assign count_eff = (32'(r_buffers_in_use) > 32'(POOL_DEPTH)) ? CW'(POOL_DEPTH)
                                                                 : CW'(r_buffers_in_use);
    assign size_eff  = (r_buffer_bytes == '0) ? SIZE_W'(1) : r_buffer_bytes;
    assign map_cfg   = '{base: r_pool_base, size: size_eff};

    // Front end: takes items and does the range check of a free.
    fbpa_front #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_push         (push),
        .i_operation    (i_operation),
        .i_free_address (i_free_address),
        .i_map          (map_cfg),
        .i_count        (count_eff),
        .i_hold         (r_cfg_hold | back_busy),
        .o_full         (full),
        .o_cmd          (cmd_in),
        .o_cmd_push     (cmd_push),
        .i_cmd_full     (cmd_full)
    );

    fbpa_fifo #(
        .T (t_cmd)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    // Back end: owns the free ring and free flags and carries out each item.
    fbpa_back #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_init      (init_pool),
        .i_map       (map_cfg),
        .i_count     (count_eff),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (res_in),
        .o_res_push  (res_push),
        .i_res_full  (res_full),
        .o_busy      (back_busy)
    );

    fbpa_fifo #(
        .T (t_result)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_status         = res_out.status;
    assign o_buffer_address = res_out.addr;

endmodule

>>> hw/rtl/fbpa_fifo.sv
module fbpa_fifo #(
    parameter type T = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);
    import fbpa_pkg::*;

    T               r_mem [Q_DEPTH];
    logic [QPW-1:0] r_wp;
    logic [QPW-1:0] r_rp;
    logic [QPW:0]   r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == (QPW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> hw/rtl/fbpa_front.sv
module fbpa_front #(
    parameter int POOL_DEPTH = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_push,
    input  logic                            i_operation,
    input  logic [fbpa_pkg::ADDR_W-1:0]     i_free_address,
    input  fbpa_pkg::t_map_cfg              i_map,
    input  logic [$clog2(POOL_DEPTH+1)-1:0] i_count,
    input  logic                            i_hold,
    output logic                            o_full,
    output fbpa_pkg::t_cmd                  o_cmd,
    output logic                            o_cmd_push,
    input  logic                            i_cmd_full
);
    import fbpa_pkg::*;

    localparam int CW   = $clog2(POOL_DEPTH + 1);
    localparam int SPW  = CW + SIZE_W;
    localparam int CMPW = (SPW > ADDR_W) ? SPW : ADDR_W;

    // Pool span in bytes, kept registered so the range check is a subtract and compare.
    logic [SPW-1:0]    r_span;
    logic [SPW-1:0]    span_full;
    logic [ADDR_W-1:0] offset;
    logic              bad;

    assign span_full = i_count * i_map.size;

    always_ff @(posedge i_clk) begin
        r_span <= span_full;
    end

    assign offset = i_free_address - i_map.base;
    assign bad    = (i_free_address < i_map.base) ||
                    (CMPW'(offset) >= CMPW'(r_span));

    assign o_full     = i_cmd_full | i_hold;
    assign o_cmd_push = i_push & ~o_full;
    assign o_cmd      = '{op: i_operation, bad: bad, offset: offset};

endmodule

>>> hw/rtl/fbpa_back.sv
module fbpa_back #(
    parameter int POOL_DEPTH = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_init,
    input  fbpa_pkg::t_map_cfg              i_map,
    input  logic [$clog2(POOL_DEPTH+1)-1:0] i_count,
    input  fbpa_pkg::t_cmd                  i_cmd,
    input  logic                            i_cmd_empty,
    output logic                            o_cmd_pop,
    output fbpa_pkg::t_result               o_res,
    output logic                            o_res_push,
    input  logic                            i_res_full,
    output logic                            o_busy
);
    import fbpa_pkg::*;

    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int IW = $clog2(POOL_DEPTH);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_ALLOC_IDX = 3'd1;
    localparam logic [2:0] S_ALLOC_ADD = 3'd2;
    localparam logic [2:0] S_DIV       = 3'd3;
    localparam logic [2:0] S_FLAG_RD   = 3'd4;
    localparam logic [2:0] S_FLAG_CHK  = 3'd5;
    localparam logic [2:0] S_DONE      = 3'd6;

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] p);
        return (p == IW'(POOL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [IW-1:0] r_ring  [POOL_DEPTH];
    logic          r_flags [POOL_DEPTH];
    logic [IW-1:0] r_ring_rd;
    logic          r_flag_rd;

    logic [2:0]    r_state, n_state;
    logic          r_init_req, n_init_req;
    logic          r_clearing, n_clearing;
    logic [IW-1:0] r_clr_ptr, n_clr_ptr;
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_total, n_total;

    logic [IW-1:0]       r_idx, n_idx;
    logic [ADDR_W-1:0]   r_prod, n_prod;
    logic [ADDR_W-1:0]   r_quo, n_quo;
    logic [SIZE_W-1:0]   r_rem, n_rem;
    logic [4:0]          r_cnt, n_cnt;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [ADDR_W-1:0]   r_addr, n_addr;

    logic                ring_we;
    logic [IW-1:0]       ring_waddr;
    logic [IW-1:0]       ring_wdata;
    logic                ring_re;
    logic                flag_we;
    logic [IW-1:0]       flag_waddr;
    logic                flag_wdata;
    logic                flag_re;
    logic [IW+SIZE_W-1:0] prod_full;
    logic [SIZE_W+1:0]   trial;
    logic                trial_neg;

    assign prod_full = r_ring_rd * i_map.size;
    // One restoring division step: bring down the next dividend bit and try the divisor.
    assign trial     = {1'b0, r_rem, r_quo[ADDR_W-1]} - {2'b00, i_map.size};
    assign trial_neg = trial[SIZE_W+1];

    always_comb begin
        n_state    = r_state;
        n_init_req = r_init_req;
        n_clearing = r_clearing;
        n_clr_ptr  = r_clr_ptr;
        n_head     = r_head;
        n_tail     = r_tail;
        n_total    = r_total;
        n_idx      = r_idx;
        n_prod     = r_prod;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_status   = r_status;
        n_addr     = r_addr;
        ring_we    = 1'b0;
        ring_waddr = r_clr_ptr;
        ring_wdata = r_clr_ptr;
        ring_re    = 1'b0;
        flag_we    = 1'b0;
        flag_waddr = r_clr_ptr;
        flag_wdata = 1'b0;
        flag_re    = 1'b0;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;

        if (r_init_req) begin
            n_init_req = 1'b0;
            n_clearing = 1'b1;
            n_clr_ptr  = '0;
            n_head     = '0;
            n_tail     = (i_count >= CW'(POOL_DEPTH)) ? '0 : i_count[IW-1:0];
            n_total    = i_count;
            n_state    = S_IDLE;
        end else if (r_clearing) begin
            ring_we    = 1'b1;
            flag_we    = 1'b1;
            flag_wdata = (CW'(r_clr_ptr) < i_count);
            if (r_clr_ptr == IW'(POOL_DEPTH - 1)) begin
                n_clearing = 1'b0;
            end else begin
                n_clr_ptr = r_clr_ptr + 1'b1;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        o_cmd_pop = 1'b1;
                        n_addr    = '0;
                        if (i_cmd.op == OP_ALLOC) begin
                            if (r_total == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                ring_re = 1'b1;
                                n_head  = ring_next(r_head);
                                n_total = r_total - 1'b1;
                                n_state = S_ALLOC_IDX;
                            end
                        end else if (i_cmd.bad) begin
                            n_status = ST_INVALID;
                            n_state  = S_DONE;
                        end else begin
                            n_rem   = '0;
                            n_quo   = i_cmd.offset;
                            n_cnt   = '0;
                            n_state = S_DIV;
                        end
                    end
                end
                S_ALLOC_IDX: begin
                    flag_we    = 1'b1;
                    flag_waddr = r_ring_rd;
                    flag_wdata = 1'b0;
                    n_prod     = ADDR_W'(prod_full);
                    n_state    = S_ALLOC_ADD;
                end
                S_ALLOC_ADD: begin
                    n_addr   = i_map.base + r_prod;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end
                S_DIV: begin
                    n_rem = trial_neg ? {r_rem[SIZE_W-2:0], r_quo[ADDR_W-1]}
                                      : trial[SIZE_W-1:0];
                    n_quo = {r_quo[ADDR_W-2:0], ~trial_neg};
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == 5'd31) begin
                        n_state = S_FLAG_RD;
                    end
                end
                S_FLAG_RD: begin
                    if (r_rem != '0) begin
                        n_status = ST_INVALID;
                        n_state  = S_DONE;
                    end else if (r_quo >= ADDR_W'(POOL_DEPTH)) begin
                        n_status = ST_ALREADY_FREE;
                        n_state  = S_DONE;
                    end else begin
                        flag_re = 1'b1;
                        n_idx   = r_quo[IW-1:0];
                        n_state = S_FLAG_CHK;
                    end
                end
                S_FLAG_CHK: begin
                    n_state = S_DONE;
                    if (r_flag_rd) begin
                        n_status = ST_ALREADY_FREE;
                    end else begin
                        n_status = ST_OK;
                        if (r_total < CW'(POOL_DEPTH)) begin
                            flag_we    = 1'b1;
                            flag_waddr = r_idx;
                            flag_wdata = 1'b1;
                            ring_we    = 1'b1;
                            ring_waddr = r_tail;
                            ring_wdata = r_idx;
                            n_tail     = ring_next(r_tail);
                            n_total    = r_total + 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    if (!i_res_full) begin
                        o_res_push = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end

        if (i_init) begin
            n_init_req = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_init_req <= 1'b1;
            r_clearing <= 1'b0;
            r_clr_ptr  <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_total    <= '0;
        end else begin
            r_state    <= n_state;
            r_init_req <= n_init_req;
            r_clearing <= n_clearing;
            r_clr_ptr  <= n_clr_ptr;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_total    <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_prod   <= n_prod;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_status <= n_status;
        r_addr   <= n_addr;
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[ring_waddr] <= ring_wdata;
        end
        if (ring_re) begin
            r_ring_rd <= r_ring[r_head];
        end
        if (flag_we) begin
            r_flags[flag_waddr] <= flag_wdata;
        end
        if (flag_re) begin
            r_flag_rd <= r_flags[r_quo[IW-1:0]];
        end
    end

    assign o_res  = '{status: r_status, addr: r_addr};
    assign o_busy = r_init_req | r_clearing;

endmodule
